// File: design/rgbfp_pkg.sv
// shared types, constants and byte tables of the rgb565 display frame packer
// depends on nothing; used by every module of the block by scoped names

package rgbfp_pkg;

   localparam int MAX_SOURCE_WIDTH = 1024;
   localparam int MAX_FRAME_HEIGHT = 512;

   // configuration field widths
   localparam int SW_W   = 11;
   localparam int WS_W   = 10;
   localparam int FW_W   = 11;
   localparam int FH_W   = 10;
   localparam int DISP_W = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // counter widths and the wider widths used for compares
   localparam int COL_W = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
   localparam int ROW_W = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
   localparam int EW_W  = ((COL_W + 1) > SW_W) ? (COL_W + 1) : SW_W;
   localparam int EH_W  = ((ROW_W + 1) > FH_W) ? (ROW_W + 1) : FH_W;
   localparam int WIN_W = ((COL_W > FW_W) ? COL_W : FW_W) + 1;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_NUMBER = 3'd4;

   // reset values of the registers
   localparam logic [SW_W-1:0]   RST_SOURCE_WIDTH   = 11'd960;
   localparam logic [WS_W-1:0]   RST_WINDOW_START   = 10'd0;
   localparam logic [FW_W-1:0]   RST_FRAME_WIDTH    = 11'd480;
   localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT   = 10'd272;
   localparam logic [DISP_W-1:0] RST_DISPLAY_NUMBER = 8'd0;

   // byte kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_COMMAND = 2'd1;
   localparam logic [1:0] KIND_PIXEL   = 2'd2;
   localparam logic [1:0] KIND_FOOTER  = 2'd3;

   // last byte index of each section
   localparam logic [3:0] HDR_LAST = 4'd15;
   localparam logic [3:0] CMD_LAST = 4'd3;
   localparam logic [3:0] PIX_LAST = 4'd1;
   localparam logic [3:0] FTR_LAST = 4'd7;

   typedef struct packed {
      logic [SW_W-1:0]   source_width;
      logic [WS_W-1:0]   window_start;
      logic [FW_W-1:0]   frame_width;
      logic [FH_W-1:0]   frame_height;
      logic [DISP_W-1:0] display_number;
   } cfg_type;

   typedef struct packed {
      logic        header;
      logic        footer;
      logic [15:0] pixel;
   } entry_type;

   function automatic logic [7:0] header_byte(input logic [3:0] idx, input cfg_type cfg);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         4'd0:    b = 8'h84;
         4'd2:    b = cfg.display_number;
         4'd3:    b = 8'h60;
         4'd12:   b = {5'd0, cfg.frame_width[10:8]};
         4'd13:   b = cfg.frame_width[7:0];
         4'd14:   b = {6'd0, cfg.frame_height[9:8]};
         4'd15:   b = cfg.frame_height[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] command_byte(input logic [3:0] idx);
      return (idx == 4'd2) ? 8'hFF : 8'h00;
   endfunction

   function automatic logic [7:0] footer_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h03;
         4'd4:    b = 8'h40;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: design/rgbfp_front.sv
// front part: column/row tracking, window test and rgb565 packing of each item
// depends on rgbfp_pkg

module rgbfp_front (
   input  logic                clock,
   input  logic                reset,
   input  rgbfp_pkg::cfg_type  cfg,
   input  logic                accept,
   input  logic [7:0]          blue,
   input  logic [7:0]          green,
   input  logic [7:0]          red,
   output logic                push,
   output rgbfp_pkg::entry_type entry
);

   logic [rgbfp_pkg::COL_W-1:0] col_ff, col_in;
   logic [rgbfp_pkg::ROW_W-1:0] row_ff, row_in;

   logic [rgbfp_pkg::EW_W-1:0]  eff_width;
   logic [rgbfp_pkg::EH_W-1:0]  eff_height;
   logic [rgbfp_pkg::EW_W-1:0]  col_next_w;
   logic [rgbfp_pkg::EH_W-1:0]  row_next_h;
   logic [rgbfp_pkg::WIN_W-1:0] col_x, win_start, win_end;
   logic                        in_window;

   always_comb begin
      if (cfg.source_width == '0) begin
         eff_width = rgbfp_pkg::EW_W'(1);
      end else if (32'(cfg.source_width) > 32'(rgbfp_pkg::MAX_SOURCE_WIDTH)) begin
         eff_width = rgbfp_pkg::EW_W'(rgbfp_pkg::MAX_SOURCE_WIDTH);
      end else begin
         eff_width = rgbfp_pkg::EW_W'(cfg.source_width);
      end
      if (cfg.frame_height == '0) begin
         eff_height = rgbfp_pkg::EH_W'(1);
      end else if (32'(cfg.frame_height) > 32'(rgbfp_pkg::MAX_FRAME_HEIGHT)) begin
         eff_height = rgbfp_pkg::EH_W'(rgbfp_pkg::MAX_FRAME_HEIGHT);
      end else begin
         eff_height = rgbfp_pkg::EH_W'(cfg.frame_height);
      end
   end

   assign col_next_w = rgbfp_pkg::EW_W'(col_ff) + rgbfp_pkg::EW_W'(1);
   assign row_next_h = rgbfp_pkg::EH_W'(row_ff) + rgbfp_pkg::EH_W'(1);

   assign col_x     = rgbfp_pkg::WIN_W'(col_ff);
   assign win_start = rgbfp_pkg::WIN_W'(cfg.window_start);
   assign win_end   = rgbfp_pkg::WIN_W'(cfg.window_start) + rgbfp_pkg::WIN_W'(cfg.frame_width);
   assign in_window = (col_x >= win_start) && (col_x < win_end);

   assign push = accept && in_window;

   always_comb begin
      entry.header = (col_x == win_start) && (row_ff == '0);
      entry.footer = ((col_x + rgbfp_pkg::WIN_W'(1)) == win_end) &&
                     (row_next_h == eff_height);
      entry.pixel  = {red[7:3], green[7:2], blue[7:3]};
   end

   // raster position advances on every accepted item, in window or not
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next_w >= eff_width) begin
            col_in = '0;
            row_in = (row_next_h >= eff_height) ? '0 : row_next_h[rgbfp_pkg::ROW_W-1:0];
         end else begin
            col_in = col_next_w[rgbfp_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: design/rgbfp_queue.sv
// short queue of classified items between the front and back parts
// depends on rgbfp_pkg

module rgbfp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rgbfp_pkg::entry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output rgbfp_pkg::entry_type head
);

   rgbfp_pkg::entry_type         q_ff [rgbfp_pkg::QDEPTH];
   logic [rgbfp_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [rgbfp_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == rgbfp_pkg::QCNT_W'(rgbfp_pkg::QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == rgbfp_pkg::QPTR_W'(rgbfp_pkg::QDEPTH - 1)) ? '0 :
                 wr_ff + rgbfp_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == rgbfp_pkg::QPTR_W'(rgbfp_pkg::QDEPTH - 1)) ? '0 :
                 rd_ff + rgbfp_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + rgbfp_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - rgbfp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: design/rgbfp_back.sv
// back part: expands a queued item into its pixel bytes, with header and command
// bytes before and footer bytes after it where flagged; depends on rgbfp_pkg

module rgbfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbfp_pkg::cfg_type   cfg,
   input  logic                 head_valid,
   input  rgbfp_pkg::entry_type head,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_data_byte,
   output logic [1:0]           rsp_byte_kind,
   output logic                 rsp_run_last
);

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_COMMAND = 4'b0010,
      PH_PIXEL   = 4'b0100,
      PH_FOOTER  = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic        first_ff, first_in;
   logic [3:0]  idx_ff, idx_in, cur_idx;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic        adv;
   logic        item_done;

   // a fresh item starts at the header or straight at its pixel bytes
   assign cur_phase = first_ff ? (head.header ? PH_HEADER : PH_PIXEL) : phase_ff;
   assign cur_idx   = first_ff ? 4'd0 : idx_ff;

   assign adv   = head_valid && (!out_valid_ff || rsp_pop);
   assign q_pop = adv && item_done;

   always_comb begin
      byte_in   = byte_ff;
      kind_in   = kind_ff;
      last_in   = 1'b0;
      item_done = 1'b0;
      phase_in  = cur_phase;
      idx_in    = cur_idx + 4'd1;
      unique case (cur_phase)
         PH_HEADER: begin
            byte_in = rgbfp_pkg::header_byte(cur_idx, cfg);
            kind_in = rgbfp_pkg::KIND_HEADER;
            if (cur_idx == rgbfp_pkg::HDR_LAST) begin
               phase_in = PH_COMMAND;
               idx_in   = 4'd0;
            end
         end
         PH_COMMAND: begin
            byte_in = rgbfp_pkg::command_byte(cur_idx);
            kind_in = rgbfp_pkg::KIND_COMMAND;
            if (cur_idx == rgbfp_pkg::CMD_LAST) begin
               phase_in = PH_PIXEL;
               idx_in   = 4'd0;
            end
         end
         PH_PIXEL: begin
            byte_in = (cur_idx == 4'd0) ? head.pixel[15:8] : head.pixel[7:0];
            kind_in = rgbfp_pkg::KIND_PIXEL;
            if (cur_idx == rgbfp_pkg::PIX_LAST) begin
               phase_in = PH_FOOTER;
               idx_in   = 4'd0;
               if (!head.footer) begin
                  item_done = 1'b1;
                  last_in   = 1'b1;
               end
            end
         end
         PH_FOOTER: begin
            byte_in = rgbfp_pkg::footer_byte(cur_idx);
            kind_in = rgbfp_pkg::KIND_FOOTER;
            if (cur_idx == rgbfp_pkg::FTR_LAST) begin
               item_done = 1'b1;
               last_in   = 1'b1;
               idx_in    = 4'd0;
            end
         end
         default: begin
            item_done = 1'b1;
            idx_in    = 4'd0;
         end
      endcase
   end

   assign first_in     = adv ? item_done : first_ff;
   assign out_valid_in = adv ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PIXEL;
         first_ff     <= 1'b1;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         first_ff     <= first_in;
         if (adv) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byte_ff <= byte_in;
         kind_ff <= kind_in;
         last_ff <= last_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_data_byte = byte_ff;
   assign rsp_byte_kind = kind_ff;
   assign rsp_run_last  = last_ff;

endmodule

// File: design/rgb565_display_frame_packer.sv
// top level of the rgb565 display frame packer: registers, front, queue and back
// depends on rgbfp_pkg, rgbfp_front, rgbfp_queue, rgbfp_back

// Takes raster-order BGR source pixels and emits the byte stream of one display
// window: header and command before the first window pixel, two RGB565 bytes per
// window pixel, footer after the last one. Pixels outside the window are taken
// one per clock and produce nothing as long as the two-entry queue between the
// front and back halves has room. Each window pixel puts two bytes on the one-byte
// result port; with header and command the first pixel of a frame gives 22 bytes,
// and with the footer the last one gives 10. Registers are to be written through
// the csr port only while the block is idle; the block itself does not enforce
// this. csr_ready is always high.

module rgb565_display_frame_packer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_blue,
   input  logic [7:0]                          req_green,
   input  logic [7:0]                          req_red,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [7:0]                          rsp_data_byte,
   output logic [1:0]                          rsp_byte_kind,
   output logic                                rsp_run_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rgbfp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rgbfp_pkg::CSR_DATA_W-1:0]    csr_data
);

   rgbfp_pkg::cfg_type   cfg_ff, cfg_in;
   rgbfp_pkg::entry_type entry, head;
   logic                 accept;
   logic                 push;
   logic                 q_full;
   logic                 head_valid;
   logic                 q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rgbfp_pkg::CSR_SOURCE_WIDTH:
               cfg_in.source_width = csr_data[rgbfp_pkg::SW_W-1:0];
            rgbfp_pkg::CSR_WINDOW_START:
               cfg_in.window_start = csr_data[rgbfp_pkg::WS_W-1:0];
            rgbfp_pkg::CSR_FRAME_WIDTH:
               cfg_in.frame_width = csr_data[rgbfp_pkg::FW_W-1:0];
            rgbfp_pkg::CSR_FRAME_HEIGHT:
               cfg_in.frame_height = csr_data[rgbfp_pkg::FH_W-1:0];
            rgbfp_pkg::CSR_DISPLAY_NUMBER:
               cfg_in.display_number = csr_data[rgbfp_pkg::DISP_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width   <= rgbfp_pkg::RST_SOURCE_WIDTH;
         cfg_ff.window_start   <= rgbfp_pkg::RST_WINDOW_START;
         cfg_ff.frame_width    <= rgbfp_pkg::RST_FRAME_WIDTH;
         cfg_ff.frame_height   <= rgbfp_pkg::RST_FRAME_HEIGHT;
         cfg_ff.display_number <= rgbfp_pkg::RST_DISPLAY_NUMBER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   rgbfp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .blue   (req_blue),
      .green  (req_green),
      .red    (req_red),
      .push   (push),
      .entry  (entry)
   );

   rgbfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rgbfp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head          (head),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data_byte (rsp_data_byte),
      .rsp_byte_kind (rsp_byte_kind),
      .rsp_run_last  (rsp_run_last)
   );

endmodule
